[sv/sst_pkg.sv]
// Shared types for the scoped symbol table: opcodes, status codes, controller
// states and the entry memory control group. No dependencies.
package sst_pkg;

  typedef enum logic [2:0] {
    OP_DEFINE     = 3'd0,
    OP_LOOKUP_CUR = 3'd1,
    OP_LOOKUP_ALL = 3'd2,
    OP_UPDATE     = 3'd3,
    OP_OPEN       = 3'd4,
    OP_CLOSE      = 3'd5
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_FULL      = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_UNDERFLOW = 3'd4,
    ST_BAD_SLOT  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_CLOSE_WAIT
  } state_e;

  typedef struct packed {
    logic rd_en;
    logic wr_key;
    logic wr_value;
  } mem_ctl_t;

endpackage

[sv/scoped_symbol_table.sv]
// Scoped symbol table top level: command port, controller, scope start store.
// Depends on sst_pkg and sst_entry_mem.
//
// A command beat is taken when start is high and busy is low; each command
// gives exactly one result, shown on the result ports for one cycle under
// result_valid_o, which the receiver must take then. Define, update and open
// return their result in the cycle after the beat and leave busy low. Close
// also answers in the next cycle; when the enclosing scope is not the
// outermost, busy stays high for one cycle while its start is read back from
// the scope store. A lookup scans the entry memory newest first at one read a
// cycle through its single port, with busy high until the scan ends; the result
// is registered on the first hit, once the last entry of the range has missed,
// or, for an empty range, in the cycle after the beat. Only the low KEY_BITS
// bits of name_key_i are stored and compared. found_slot_o and scope_now_o
// carry the low bits of the slot and of the level.
module scoped_symbol_table #(
  parameter int TABLE_DEPTH = 32,
  parameter int SCOPE_DEPTH = 8,
  parameter int KEY_BITS    = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         opcode_i,
  input  logic [63:0]        name_key_i,
  input  logic signed [31:0] new_value_i,
  input  logic [4:0]         target_slot_i,
  output logic               result_valid_o,
  output logic [2:0]         status_o,
  output logic [4:0]         found_slot_o,
  output logic signed [31:0] found_value_o,
  output logic [2:0]         scope_now_o
);

  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int LW   = (SCOPE_DEPTH > 1) ? $clog2(SCOPE_DEPTH) : 1;
  localparam int CMPW = (CW > 5) ? CW : 5;

  sst_pkg::state_e state_q, state_d;

  logic [CW-1:0] count_q, count_d;
  logic [LW-1:0] level_q, level_d;
  logic [CW-1:0] cur_start_q, cur_start_d;

  logic [AW-1:0] ptr_q, ptr_d;
  logic [AW-1:0] pend_addr_q, pend_addr_d;
  logic          more_q, more_d;
  logic          pend_q, pend_d;
  logic [CW-1:0] floor_q, floor_d;

  logic [KEY_BITS-1:0] key_q, key_d;

  logic                valid_q, valid_d;
  sst_pkg::status_e    status_q, status_d;
  logic [4:0]          slot_q, slot_d;
  logic signed [31:0]  value_q, value_d;

  logic [CW-1:0] scopes_q [SCOPE_DEPTH];
  logic [CW-1:0] sc_rd_q;
  logic          sc_we, sc_re;
  logic [LW-1:0] sc_waddr, sc_raddr;

  sst_pkg::mem_ctl_t   mem_ctl;
  logic [AW-1:0]       mem_addr;
  logic [KEY_BITS-1:0] rkey;
  logic signed [31:0]  rval;

  sst_pkg::opcode_e op;
  logic             accept;
  logic             is_lookup;
  logic [CW-1:0]    lk_floor;
  logic             lk_empty;
  logic             close_rd;
  logic             hit;

  assign op        = sst_pkg::opcode_e'(opcode_i);
  assign accept    = start && (state_q == sst_pkg::S_IDLE);
  assign is_lookup = (op == sst_pkg::OP_LOOKUP_CUR) || (op == sst_pkg::OP_LOOKUP_ALL);
  assign lk_floor  = (op == sst_pkg::OP_LOOKUP_CUR) ? cur_start_q : '0;
  assign lk_empty  = (count_q == lk_floor);
  assign close_rd  = (op == sst_pkg::OP_CLOSE) && (level_q > LW'(1));
  assign hit       = pend_q && (rkey == key_q);

  sst_entry_mem #(
    .DEPTH    (TABLE_DEPTH),
    .KEY_BITS (KEY_BITS),
    .AW       (AW)
  ) u_entry_mem (
    .clk_i  (clk_i),
    .ctl_i  (mem_ctl),
    .addr_i (mem_addr),
    .wkey_i (name_key_i[KEY_BITS-1:0]),
    .wval_i (new_value_i),
    .rkey_o (rkey),
    .rval_o (rval)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sst_pkg::S_IDLE: begin
        if (accept && is_lookup && !lk_empty) begin
          state_d = sst_pkg::S_SCAN;
        end else if (accept && close_rd) begin
          state_d = sst_pkg::S_CLOSE_WAIT;
        end
      end
      sst_pkg::S_SCAN: begin
        if (hit || !more_q) begin
          state_d = sst_pkg::S_IDLE;
        end
      end
      sst_pkg::S_CLOSE_WAIT: begin
        state_d = sst_pkg::S_IDLE;
      end
      default: begin
        state_d = sst_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    count_d     = count_q;
    level_d     = level_q;
    cur_start_d = cur_start_q;
    ptr_d       = ptr_q;
    pend_addr_d = pend_addr_q;
    more_d      = more_q;
    pend_d      = pend_q;
    floor_d     = floor_q;
    key_d       = key_q;
    valid_d     = 1'b0;
    status_d    = status_q;
    slot_d      = slot_q;
    value_d     = value_q;
    sc_we       = 1'b0;
    sc_re       = 1'b0;
    sc_waddr    = level_q + LW'(1);
    sc_raddr    = level_q - LW'(1);
    mem_ctl     = '0;
    mem_addr    = ptr_q;

    unique case (state_q)
      sst_pkg::S_IDLE: begin
        if (accept) begin
          valid_d  = 1'b1;
          status_d = sst_pkg::ST_OK;
          slot_d   = '0;
          value_d  = '0;
          case (op)
            sst_pkg::OP_DEFINE: begin
              if (count_q == CW'(TABLE_DEPTH)) begin
                status_d = sst_pkg::ST_FULL;
              end else begin
                mem_addr       = AW'(count_q);
                mem_ctl.wr_key   = 1'b1;
                mem_ctl.wr_value = 1'b1;
                slot_d         = 5'(count_q);
                count_d        = count_q + CW'(1);
              end
            end
            sst_pkg::OP_LOOKUP_CUR, sst_pkg::OP_LOOKUP_ALL: begin
              key_d = name_key_i[KEY_BITS-1:0];
              if (lk_empty) begin
                status_d = sst_pkg::ST_NOT_FOUND;
              end else begin
                valid_d = 1'b0;
                ptr_d   = AW'(count_q - CW'(1));
                floor_d = lk_floor;
                more_d  = 1'b1;
                pend_d  = 1'b0;
              end
            end
            sst_pkg::OP_UPDATE: begin
              slot_d = target_slot_i;
              if (CMPW'(target_slot_i) >= CMPW'(count_q)) begin
                status_d = sst_pkg::ST_BAD_SLOT;
              end else begin
                mem_addr         = AW'(target_slot_i);
                mem_ctl.wr_value = 1'b1;
              end
            end
            sst_pkg::OP_OPEN: begin
              if (level_q == LW'(SCOPE_DEPTH - 1)) begin
                status_d = sst_pkg::ST_OVERFLOW;
              end else begin
                sc_we       = 1'b1;
                level_d     = level_q + LW'(1);
                cur_start_d = count_q;
              end
            end
            sst_pkg::OP_CLOSE: begin
              if (level_q == '0) begin
                status_d = sst_pkg::ST_UNDERFLOW;
              end else begin
                count_d = cur_start_q;
                level_d = level_q - LW'(1);
                if (close_rd) begin
                  sc_re = 1'b1;
                end else begin
                  cur_start_d = '0;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      sst_pkg::S_SCAN: begin
        if (hit) begin
          valid_d  = 1'b1;
          status_d = sst_pkg::ST_OK;
          slot_d   = 5'(pend_addr_q);
          value_d  = rval;
          pend_d   = 1'b0;
          more_d   = 1'b0;
        end else if (!more_q) begin
          valid_d  = 1'b1;
          status_d = sst_pkg::ST_NOT_FOUND;
          slot_d   = '0;
          value_d  = '0;
          pend_d   = 1'b0;
        end else begin
          mem_addr      = ptr_q;
          mem_ctl.rd_en = 1'b1;
          pend_d        = 1'b1;
          pend_addr_d   = ptr_q;
          if (CW'(ptr_q) == floor_q) begin
            more_d = 1'b0;
          end else begin
            ptr_d = ptr_q - AW'(1);
          end
        end
      end
      sst_pkg::S_CLOSE_WAIT: begin
        cur_start_d = sc_rd_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sst_pkg::S_IDLE;
      count_q     <= '0;
      level_q     <= '0;
      cur_start_q <= '0;
      more_q      <= 1'b0;
      pend_q      <= 1'b0;
      valid_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      level_q     <= level_d;
      cur_start_q <= cur_start_d;
      more_q      <= more_d;
      pend_q      <= pend_d;
      valid_q     <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q       <= ptr_d;
    pend_addr_q <= pend_addr_d;
    floor_q     <= floor_d;
    key_q       <= key_d;
    status_q    <= status_d;
    slot_q      <= slot_d;
    value_q     <= value_d;
  end

  always_ff @(posedge clk_i) begin
    if (sc_we) begin
      scopes_q[sc_waddr] <= count_q;
    end
    if (sc_re) begin
      sc_rd_q <= scopes_q[sc_raddr];
    end
  end

  assign busy           = (state_q != sst_pkg::S_IDLE);
  assign result_valid_o = valid_q;
  assign status_o       = status_q;
  assign found_slot_o   = slot_q;
  assign found_value_o  = value_q;
  assign scope_now_o    = 3'(level_q);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_start_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sst_pkg::S_IDLE) |-> (cur_start_q <= count_q))
    else $error("scope start above entry count");

  a_quick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !is_lookup) |=> result_valid_o)
    else $error("missing result after non-lookup command");

  a_scan_stays_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sst_pkg::S_SCAN && more_q) |-> (CW'(ptr_q) >= floor_q && CW'(ptr_q) < count_q))
    else $error("scan pointer outside live range");

  a_no_result_mid_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sst_pkg::S_SCAN) |-> !result_valid_o)
    else $error("result strobe during a scan");

endmodule

[sv/sst_entry_mem.sv]
// Entry store of the scoped symbol table: key and value per slot, one shared
// port, registered read data. Depends on sst_pkg for the control group.
module sst_entry_mem #(
  parameter int DEPTH    = 32,
  parameter int KEY_BITS = 64,
  parameter int AW       = 5
) (
  input  logic                clk_i,
  input  sst_pkg::mem_ctl_t   ctl_i,
  input  logic [AW-1:0]       addr_i,
  input  logic [KEY_BITS-1:0] wkey_i,
  input  logic signed [31:0]  wval_i,
  output logic [KEY_BITS-1:0] rkey_o,
  output logic signed [31:0]  rval_o
);

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic signed [31:0]  value;
  } entry_t;

  entry_t mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_key) begin
      mem_q[addr_i].key <= wkey_i;
    end
    if (ctl_i.wr_value) begin
      mem_q[addr_i].value <= wval_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rkey_o <= mem_q[addr_i].key;
      rval_o <= mem_q[addr_i].value;
    end
  end

endmodule
